FILE: hdl/dnsd_pkg.sv
// dnsd_pkg: shared types and constants of the dns name decompressor
// depends on nothing; used by every other file of the block but dnsd_if
`default_nettype none

package dnsd_pkg;

   localparam int LABEL_MAX = 63;
   localparam int PTR_BITS  = 14;
   localparam int WORD_BYTES = 8;

   typedef enum logic {
      OP_STORE  = 1'b0,
      OP_DECOMP = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_PTR_END  = 3'd1,
      ST_JUMPS    = 3'd2,
      ST_BEYOND   = 3'd3,
      ST_OVERRUN  = 3'd4,
      ST_TOO_LONG = 3'd5
   } status_type;

   typedef struct packed {
      logic       store;
      logic       start;
      logic       push;
      logic       adv;
      logic       jump;
      logic       load_hi;
      logic       load_rem;
      logic       dec_rem;
      logic       emit;
      logic       last;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic start_beyond;
      logic byte_zero;
      logic byte_ptr;
      logic ptr_at_end;
      logic jumps_over;
      logic target_beyond;
      logic label_overrun;
      logic label_too_long;
      logic zero_too_long;
      logic rem_last;
      logic fill_full;
      logic out_free;
   } flags_type;

endpackage

`default_nettype wire

FILE: hdl/dnsd_if.sv
// dnsd_req_if and dnsd_rsp_if: valid/ready channels of the decompressor
// depends on nothing
`default_nettype none

interface dnsd_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [8:0] address;
   logic [7:0] byte_value;
   logic [9:0] message_length;

   modport source (output valid, opcode, address, byte_value, message_length,
                   input ready);
   modport sink (input valid, opcode, address, byte_value, message_length,
                 output ready);
endinterface

interface dnsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_word;
   logic [3:0]  byte_count;
   logic        last;
   logic [2:0]  status;

   modport source (output valid, out_word, byte_count, last, status,
                   input ready);
   modport sink (input valid, out_word, byte_count, last, status,
                 output ready);
endinterface

`default_nettype wire

FILE: hdl/dnsd_ctrl.sv
// dnsd_ctrl: state machine that sequences store, walk and delivery
// depends on dnsd_pkg; drives dnsd_datapath through cmd_type
`default_nettype none

module dnsd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_opcode,
   output logic                     req_ready,
   input  wire dnsd_pkg::flags_type flags,
   output dnsd_pkg::cmd_type        cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_WALK = 5'b00010,
      S_PTR2 = 5'b00100,
      S_COPY = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   dnsd_pkg::status_type stat_ff, stat_in;
   logic                 can_push;

   assign can_push  = !flags.fill_full || flags.out_free;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      stat_in  = stat_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_opcode == dnsd_pkg::OP_STORE) begin
                  cmd.store = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  if (flags.start_beyond) begin
                     stat_in  = dnsd_pkg::ST_BEYOND;
                     state_in = S_DONE;
                  end else begin
                     stat_in  = dnsd_pkg::ST_OK;
                     state_in = S_WALK;
                  end
               end
            end
         end
         S_WALK: begin
            priority if (flags.byte_zero) begin
               if (flags.zero_too_long) begin
                  stat_in  = dnsd_pkg::ST_TOO_LONG;
                  state_in = S_DONE;
               end else if (can_push) begin
                  cmd.push = 1'b1;
                  stat_in  = dnsd_pkg::ST_OK;
                  state_in = S_DONE;
               end
            end else if (flags.byte_ptr) begin
               priority if (flags.ptr_at_end) begin
                  stat_in  = dnsd_pkg::ST_PTR_END;
                  state_in = S_DONE;
               end else if (flags.jumps_over) begin
                  stat_in  = dnsd_pkg::ST_JUMPS;
                  state_in = S_DONE;
               end else begin
                  cmd.load_hi = 1'b1;
                  cmd.adv     = 1'b1;
                  state_in    = S_PTR2;
               end
            end else begin
               if (flags.label_overrun) begin
                  stat_in  = dnsd_pkg::ST_OVERRUN;
                  state_in = S_DONE;
               end else if (flags.label_too_long) begin
                  stat_in  = dnsd_pkg::ST_TOO_LONG;
                  state_in = S_DONE;
               end else if (can_push) begin
                  cmd.push     = 1'b1;
                  cmd.adv      = 1'b1;
                  cmd.load_rem = 1'b1;
                  state_in     = S_COPY;
               end
            end
         end
         S_PTR2: begin
            if (flags.target_beyond) begin
               stat_in  = dnsd_pkg::ST_BEYOND;
               state_in = S_DONE;
            end else begin
               cmd.jump = 1'b1;
               state_in = S_WALK;
            end
         end
         S_COPY: begin
            if (can_push) begin
               cmd.push    = 1'b1;
               cmd.adv     = 1'b1;
               cmd.dec_rem = 1'b1;
               if (flags.rem_last) begin
                  state_in = S_WALK;
               end
            end
         end
         S_DONE: begin
            if (flags.out_free) begin
               cmd.emit = 1'b1;
               if (stat_ff != dnsd_pkg::ST_OK && flags.fill_full) begin
                  // full word goes out first, the error comes in an empty word
                  cmd.last   = 1'b0;
                  cmd.status = dnsd_pkg::ST_OK;
               end else begin
                  cmd.last   = 1'b1;
                  cmd.status = stat_ff;
                  state_in   = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stat_ff  <= dnsd_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         stat_ff  <= stat_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/dnsd_datapath.sv
// dnsd_datapath: message memory, walk registers, word packer, result register
// depends on dnsd_pkg; commanded by dnsd_ctrl
`default_nettype none

module dnsd_datapath #(
   parameter int MSG_BYTES  = 512,
   parameter int MAX_JUMPS  = 20,
   parameter int NAME_LIMIT = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [8:0]        address,
   input  wire logic [7:0]        byte_value,
   input  wire logic [9:0]        message_length,
   input  wire dnsd_pkg::cmd_type cmd,
   output dnsd_pkg::flags_type    flags,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [63:0]            rsp_out_word,
   output logic [3:0]             rsp_byte_count,
   output logic                   rsp_last,
   output logic [2:0]             rsp_status
);

   localparam int AW  = $clog2(MSG_BYTES);
   localparam int LW  = $clog2(MSG_BYTES + 1);
   localparam int CW  = (LW + 1 > dnsd_pkg::PTR_BITS) ? LW + 1 : dnsd_pkg::PTR_BITS;
   localparam int JW  = $clog2(MAX_JUMPS + 2);
   localparam int NW  = $clog2(NAME_LIMIT + 1);
   localparam int NW1 = NW + 1;

   logic [7:0]    mem [MSG_BYTES];
   logic [7:0]    rd_ff;

   logic [AW-1:0] pos_ff, pos_in;
   logic [LW-1:0] len_ff, len_in, len_sat;
   logic [JW-1:0] jump_ff, jump_in;
   logic [NW-1:0] nlen_ff, nlen_in;
   logic [5:0]    hi_ff, hi_in;
   logic [5:0]    rem_ff, rem_in;
   logic [63:0]   pack_ff, pack_in;
   logic [3:0]    fill_ff, fill_in;

   logic          out_vld_ff, out_vld_in;
   logic [63:0]   outw_ff, outw_in;
   logic [3:0]    outcnt_ff, outcnt_in;
   logic          outlast_ff, outlast_in;
   logic [2:0]    outstat_ff, outstat_in;

   logic [CW-1:0] addr_ext;
   logic [CW-1:0] pos_ext;
   logic [CW-1:0] len_ext;
   logic [CW-1:0] target_ext;
   logic          out_free;
   logic          fill_full;

   assign addr_ext   = CW'(address);
   assign pos_ext    = CW'(pos_ff);
   assign len_ext    = CW'(len_ff);
   assign target_ext = CW'({hi_ff, rd_ff});
   assign out_free   = !out_vld_ff || rsp_ready;
   assign fill_full  = (fill_ff == 4'(dnsd_pkg::WORD_BYTES));

   // saturate the message length to the store size
   assign len_sat = (CW'(message_length) > CW'(MSG_BYTES)) ? LW'(MSG_BYTES)
                                                           : LW'(message_length);

   always_comb begin
      flags.start_beyond   = addr_ext >= CW'(len_sat);
      flags.byte_zero      = (rd_ff == 8'd0);
      flags.byte_ptr       = (rd_ff > 8'(dnsd_pkg::LABEL_MAX));
      flags.ptr_at_end     = (pos_ext + CW'(1)) >= len_ext;
      flags.jumps_over     = jump_ff > JW'(MAX_JUMPS);
      flags.target_beyond  = target_ext >= len_ext;
      flags.label_overrun  = (pos_ext + CW'(rd_ff) + CW'(1)) >= len_ext;
      flags.label_too_long = (NW1'(nlen_ff) + NW1'(rd_ff) + NW1'(2)) > NW1'(NAME_LIMIT);
      flags.zero_too_long  = (NW1'(nlen_ff) + NW1'(1)) > NW1'(NAME_LIMIT);
      flags.rem_last       = (rem_ff == 6'd1);
      flags.fill_full      = fill_full;
      flags.out_free       = out_free;
   end

   always_comb begin
      pos_in     = pos_ff;
      len_in     = len_ff;
      jump_in    = jump_ff;
      nlen_in    = nlen_ff;
      hi_in      = hi_ff;
      rem_in     = rem_ff;
      pack_in    = pack_ff;
      fill_in    = fill_ff;
      out_vld_in = out_vld_ff && !rsp_ready;
      outw_in    = outw_ff;
      outcnt_in  = outcnt_ff;
      outlast_in = outlast_ff;
      outstat_in = outstat_ff;

      if (cmd.start) begin
         pos_in = addr_ext[AW-1:0];
      end else if (cmd.jump) begin
         pos_in = target_ext[AW-1:0];
      end else if (cmd.adv) begin
         pos_in = pos_ff + AW'(1);
      end

      if (cmd.start) begin
         len_in  = len_sat;
         jump_in = '0;
         nlen_in = '0;
         pack_in = '0;
         fill_in = '0;
      end
      if (cmd.jump) begin
         jump_in = jump_ff + JW'(1);
      end
      if (cmd.load_hi) begin
         hi_in = rd_ff[5:0];
      end
      if (cmd.load_rem) begin
         rem_in = rd_ff[5:0];
      end else if (cmd.dec_rem) begin
         rem_in = rem_ff - 6'd1;
      end

      if (cmd.push) begin
         nlen_in = nlen_ff + NW'(1);
         if (fill_full) begin
            // during the walk a full word leaves only once another byte follows it
            out_vld_in = 1'b1;
            outw_in    = pack_ff;
            outcnt_in  = fill_ff;
            outlast_in = 1'b0;
            outstat_in = dnsd_pkg::ST_OK;
            pack_in    = {56'd0, rd_ff};
            fill_in    = 4'd1;
         end else begin
            pack_in[{fill_ff[2:0], 3'b000} +: 8] = rd_ff;
            fill_in = fill_ff + 4'd1;
         end
      end

      if (cmd.emit) begin
         out_vld_in = 1'b1;
         outw_in    = pack_ff;
         outcnt_in  = fill_ff;
         outlast_in = cmd.last;
         outstat_in = cmd.status;
         pack_in    = '0;
         fill_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store && (addr_ext < CW'(MSG_BYTES))) begin
         mem[addr_ext[AW-1:0]] <= byte_value;
      end
      rd_ff <= mem[pos_in];
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      len_ff     <= len_in;
      jump_ff    <= jump_in;
      nlen_ff    <= nlen_in;
      hi_ff      <= hi_in;
      rem_ff     <= rem_in;
      pack_ff    <= pack_in;
      outw_ff    <= outw_in;
      outcnt_ff  <= outcnt_in;
      outlast_ff <= outlast_in;
      outstat_ff <= outstat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         fill_ff    <= '0;
      end else begin
         out_vld_ff <= out_vld_in;
         fill_ff    <= fill_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_out_word   = outw_ff;
   assign rsp_byte_count = outcnt_ff;
   assign rsp_last       = outlast_ff;
   assign rsp_status     = outstat_ff;

endmodule

`default_nettype wire

FILE: hdl/dns_name_decompressor_unit.sv
// dns_name_decompressor_unit: top level of the dns name decompressor
// depends on dnsd_pkg, dnsd_if, dnsd_ctrl and dnsd_datapath
//
//   channel | dir | fields                                         | words per item
//   req     | in  | opcode, address, byte_value, message_length    | 1
//   rsp     | out | out_word, byte_count, last, status             | 0 for a store,
//           |     |                                                | 1 to 32 for a decompress
//
// a store writes one byte into the message memory. a decompress starts, copies each name
// byte, follows each pointer through S_WALK and S_PTR2 and stops at a byte that ends the
// walk in an error, all paced by the single read port of the message memory, then sends
// the final word (after a full word, an error comes in an empty word). full words leave during the walk;
// a full word waiting on a stalled rsp holds the walk until it is taken.
// rsp has an output register, so a new item is taken while the last word waits.
// reset clears the control state, rsp valid and the fill count; the message memory holds what was stored.
`default_nettype none

module dns_name_decompressor_unit #(
   parameter int MSG_BYTES  = 512,
   parameter int MAX_JUMPS  = 20,
   parameter int NAME_LIMIT = 256
) (
   input wire logic clock,
   input wire logic reset,
   dnsd_req_if.sink   req,
   dnsd_rsp_if.source rsp
);

   dnsd_pkg::cmd_type   cmd;
   dnsd_pkg::flags_type flags;

   dnsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_opcode (req.opcode),
      .req_ready  (req.ready),
      .flags      (flags),
      .cmd        (cmd)
   );

   dnsd_datapath #(
      .MSG_BYTES  (MSG_BYTES),
      .MAX_JUMPS  (MAX_JUMPS),
      .NAME_LIMIT (NAME_LIMIT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .address        (req.address),
      .byte_value     (req.byte_value),
      .message_length (req.message_length),
      .cmd            (cmd),
      .flags          (flags),
      .rsp_ready      (rsp.ready),
      .rsp_valid      (rsp.valid),
      .rsp_out_word   (rsp.out_word),
      .rsp_byte_count (rsp.byte_count),
      .rsp_last       (rsp.last),
      .rsp_status     (rsp.status)
   );

endmodule

`default_nettype wire

FILE: hdl/dnsd_checker.sv
// dnsd_checker: port-level checks of the decompressor, bound to the top level
// depends on dnsd_pkg and dns_name_decompressor_unit
`default_nettype none

module dnsd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_opcode,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_last,
   input wire logic [3:0] rsp_byte_count,
   input wire logic [2:0] rsp_status
);

   // a word left waiting stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // only the final word may be short or carry an error
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_byte_count == 4'd8 &&
                                 rsp_status == dnsd_pkg::ST_OK)
      else $error("non-final word not full or has error status");

   // a good final word holds one to eight bytes, as the name ends with its zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && rsp_status == dnsd_pkg::ST_OK |->
         rsp_byte_count != 4'd0 && rsp_byte_count <= 4'd8)
      else $error("good final word has bad byte count");

   // a decompress leaves the unit busy in the cycle after it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == dnsd_pkg::OP_DECOMP |=> !req_ready)
      else $error("request taken during a walk");

   // the status field stays inside its code range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= dnsd_pkg::ST_TOO_LONG)
      else $error("rsp status out of range");

endmodule

bind dns_name_decompressor_unit dnsd_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .req_opcode     (req.opcode),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_last       (rsp.last),
   .rsp_byte_count (rsp.byte_count),
   .rsp_status     (rsp.status)
);

`default_nettype wire
